// File: hdl/bitplane_block_delta_encoder_defines.svh
// Assertion macros for the bit-plane block delta encoder.
`ifndef BITPLANE_BLOCK_DELTA_ENCODER_DEFINES_SVH
`define BITPLANE_BLOCK_DELTA_ENCODER_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define BBDE_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define BBDE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/bbde_pkg.sv
// Shared types and constants of the bit-plane block delta encoder.
`default_nettype none
package bbde_pkg;

  localparam int NumBlocks = 128;
  localparam int BlkIdxW   = $clog2(NumBlocks);
  localparam int BlkW      = 64;
  localparam int DispRows  = 16;
  localparam int RowW      = $clog2(DispRows);
  localparam int CntW      = BlkIdxW + 1;
  localparam int LenW      = 11;
  localparam int QueueW    = BlkIdxW + BlkW;

  localparam logic [3:0] KeepReload = 4'd10;

  localparam logic [1:0] FuncWrite = 2'd0;
  localparam logic [1:0] FuncTick  = 2'd1;
  localparam logic [1:0] FuncFetch = 2'd2;

  localparam logic [1:0] KindHeader = 2'd0;
  localparam logic [1:0] KindBlock  = 2'd1;
  localparam logic [1:0] KindEnd    = 2'd2;

  typedef enum logic [2:0] {
    StIdle,
    StWrWrite,
    StTick,
    StFetchRead
  } state_e;

  typedef struct packed {
    logic accept;
    logic wr_write;
    logic tick_try;
    logic tick_begin;
    logic tick_step;
    logic emit_header;
    logic fetch_end;
    logic fetch_rd;
    logic emit_block;
  } cmd_t;

  typedef struct packed {
    logic draining;
    logic q_empty;
    logic tick_live;
    logic tick_done;
    logic out_busy;
  } status_t;

endpackage
`default_nettype wire

// File: hdl/bitplane_block_delta_encoder.sv
// Top level of the bit-plane block delta encoder.
// Usage: one input channel (in_valid_i/in_ready_o) carries items whose func_i selects a
// display byte write, a frame tick or a fetch of the next record. One output channel
// (out_valid_o/out_ready_i) carries at most one record per item: frame header, block
// record or end marker, held in an output register until its transfer completes.
// Flow: a write is a read-modify-write of the eight bit-plane RAMs. A fetch presents
// an end marker straight from idle, or reads a block record from the record queue RAM
// and presents it from the fetch-read state. A surviving tick walks all 128 blocks
// through a two-stage read/compare loop, one block per cycle, and then presents its
// header; ignored ticks never leave idle. in_ready_o is low while an item is at work
// and while a result waits in the output register, so a stalled receiver stalls input.
// Reset: asynchronous, active low; the display, previous frame and pending records read
// as empty through valid bits, the keep-alive count reloads to ten, no clearing pass.
`default_nettype none
`include "bitplane_block_delta_encoder_defines.svh"
module bitplane_block_delta_encoder
  import bbde_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [1:0]         func_i,
  input  wire logic [2:0]         line_i,
  input  wire logic [6:0]         column_i,
  input  wire logic [7:0]         pixels_i,
  input  wire logic               force_req_i,
  input  wire logic               connected_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [1:0]              kind_o,
  output logic [LenW-1:0]         length_o,
  output logic [BlkIdxW-1:0]      block_index_o,
  output logic [BlkW-1:0]         block_data_o
);

  cmd_t    cmd;
  status_t status;

  bbde_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .func_i,
    .in_ready_o,
    .status_i (status),
    .cmd_o    (cmd)
  );

  bbde_datapath u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i    (cmd),
    .status_o (status),
    .line_i,
    .column_i,
    .pixels_i,
    .force_req_i,
    .connected_i,
    .out_valid_o,
    .out_ready_i,
    .kind_o,
    .length_o,
    .block_index_o,
    .block_data_o
  );

  `BBDE_ASSERT(a_ready_no_pending, clk_i, rst_ni, in_ready_o |-> !out_valid_o, "ready with result pending")
  `BBDE_ASSERT(a_emit_when_empty, clk_i, rst_ni, (cmd.emit_header || cmd.emit_block || cmd.fetch_end) |-> !out_valid_o, "result overwritten")
  `BBDE_ASSERT_NEXT(a_header_drains, clk_i, rst_ni, cmd.emit_header, status.draining && out_valid_o && (kind_o == KindHeader) && (length_o != '0), "header without draining")
  `BBDE_ASSERT_NEXT(a_end_stops, clk_i, rst_ni, cmd.fetch_end, !status.draining && (kind_o == KindEnd), "end marker left draining")

endmodule
`default_nettype wire

// File: hdl/bbde_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module bbde_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

// File: hdl/bbde_ctrl.sv
// Controller state machine of the bit-plane block delta encoder.
`default_nettype none
module bbde_ctrl
  import bbde_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic [1:0] func_i,
  output logic            in_ready_o,
  input  wire status_t    status_i,
  output cmd_t            cmd_o
);

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == StIdle) && !status_i.out_busy;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          unique case (func_i)
            FuncWrite: state_d = StWrWrite;
            FuncTick: begin
              if (!status_i.draining && status_i.tick_live) state_d = StTick;
            end
            FuncFetch: begin
              if (status_i.draining && !status_i.q_empty) state_d = StFetchRead;
            end
            default: state_d = StIdle;
          endcase
        end
      end
      StWrWrite:   state_d = StIdle;
      StTick:      if (status_i.tick_done) state_d = StIdle;
      StFetchRead: state_d = StIdle;
      default:     state_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      StIdle: begin
        cmd_o.accept = accept;
        if (accept) begin
          unique case (func_i)
            FuncWrite: ;
            FuncTick: begin
              cmd_o.tick_try   = !status_i.draining;
              cmd_o.tick_begin = !status_i.draining && status_i.tick_live;
            end
            FuncFetch: begin
              cmd_o.fetch_end = status_i.draining && status_i.q_empty;
              cmd_o.fetch_rd  = status_i.draining && !status_i.q_empty;
            end
            default: ;
          endcase
        end
      end
      StWrWrite: cmd_o.wr_write = 1'b1;
      StTick: begin
        cmd_o.emit_header = status_i.tick_done;
        cmd_o.tick_step   = !status_i.tick_done;
      end
      StFetchRead: cmd_o.emit_block = 1'b1;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// File: hdl/bbde_datapath.sv
// Datapath: display planes, previous frame, record queue and output register.
`default_nettype none
module bbde_datapath
  import bbde_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire cmd_t               cmd_i,
  output status_t                 status_o,
  input  wire logic [2:0]         line_i,
  input  wire logic [6:0]         column_i,
  input  wire logic [7:0]         pixels_i,
  input  wire logic               force_req_i,
  input  wire logic               connected_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [1:0]              kind_o,
  output logic [LenW-1:0]         length_o,
  output logic [BlkIdxW-1:0]      block_index_o,
  output logic [BlkW-1:0]         block_data_o
);

  // Display planes: one RAM per pixel bit, row = {line, column half}.
  logic [7:0][BlkW-1:0] disp_rdata, disp_wdata;
  logic [RowW-1:0]      disp_raddr;
  logic [DispRows-1:0]  disp_vld_q;

  logic [RowW-1:0] wr_row_q;
  logic [5:0]      wr_bit_q;
  logic [7:0]      wr_pix_q;
  logic            wr_vld_q;
  logic            force_q;

  logic [3:0] ka_q, ka_sel, ka_dec;

  logic [BlkIdxW-1:0]   k_q, p_k_q, fp_q;
  logic                 issue_done_q, p_vld_q, p_dvld_q, p_pvld_q;
  logic [NumBlocks-1:0] prev_vld_q;
  logic [BlkW-1:0]      prev_rdata, cur_blk, prev_blk;
  logic                 sel, proc;
  logic [CntW-1:0]      sel_cnt_q;
  logic                 draining_q;

  logic [CntW-1:0]   q_wr_q, q_rd_q;
  logic [QueueW-1:0] q_rdata;

  assign disp_raddr = cmd_i.tick_step ? {k_q[6:4], k_q[0]} : {line_i, column_i[6]};

  always_comb begin
    for (int j = 0; j < 8; j++) begin
      disp_wdata[j] = wr_vld_q ? disp_rdata[j] : '0;
      disp_wdata[j][wr_bit_q] = wr_pix_q[j];
    end
  end

  for (genvar j = 0; j < 8; j++) begin : g_plane
    bbde_ram #(.Width(BlkW), .Depth(DispRows)) u_plane (
      .clk_i,
      .we_i    (cmd_i.wr_write),
      .waddr_i (wr_row_q),
      .wdata_i (disp_wdata[j]),
      .raddr_i (disp_raddr),
      .rdata_o (disp_rdata[j])
    );
  end

  assign proc     = cmd_i.tick_step && p_vld_q;
  assign cur_blk  = p_dvld_q ? disp_rdata[p_k_q[3:1]] : '0;
  assign prev_blk = p_pvld_q ? prev_rdata : '0;
  assign sel      = (cur_blk != prev_blk) || (p_k_q == fp_q) || force_q;

  bbde_ram #(.Width(BlkW), .Depth(NumBlocks)) u_prev (
    .clk_i,
    .we_i    (proc && sel),
    .waddr_i (p_k_q),
    .wdata_i (cur_blk),
    .raddr_i (k_q),
    .rdata_o (prev_rdata)
  );

  bbde_ram #(.Width(QueueW), .Depth(NumBlocks)) u_queue (
    .clk_i,
    .we_i    (proc && sel),
    .waddr_i (q_wr_q[BlkIdxW-1:0]),
    .wdata_i ({p_k_q, cur_blk}),
    .raddr_i (q_rd_q[BlkIdxW-1:0]),
    .rdata_o (q_rdata)
  );

  // Keep-alive: reload on connect, then count down; zero ends the tick.
  assign ka_sel = connected_i ? KeepReload : ka_q;
  assign ka_dec = ka_sel - 4'd1;

  assign status_o.draining  = draining_q;
  assign status_o.q_empty   = (q_rd_q == q_wr_q);
  assign status_o.tick_live = (ka_sel != 4'd0) && (ka_dec != 4'd0);
  assign status_o.tick_done = issue_done_q && !p_vld_q;
  assign status_o.out_busy  = out_valid_o;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      wr_row_q <= {line_i, column_i[6]};
      wr_bit_q <= column_i[5:0];
      wr_pix_q <= pixels_i;
      wr_vld_q <= disp_vld_q[{line_i, column_i[6]}];
      force_q  <= force_req_i;
    end
    if (cmd_i.tick_step && !issue_done_q) begin
      p_k_q    <= k_q;
      p_dvld_q <= disp_vld_q[{k_q[6:4], k_q[0]}];
      p_pvld_q <= prev_vld_q[k_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      disp_vld_q   <= '0;
      prev_vld_q   <= '0;
      ka_q         <= KeepReload;
      k_q          <= '0;
      fp_q         <= '0;
      issue_done_q <= 1'b0;
      p_vld_q      <= 1'b0;
      sel_cnt_q    <= '0;
      draining_q   <= 1'b0;
      q_wr_q       <= '0;
      q_rd_q       <= '0;
    end else begin
      if (cmd_i.wr_write) disp_vld_q[wr_row_q] <= 1'b1;
      if (cmd_i.tick_try) ka_q <= (ka_sel != 4'd0) ? ka_dec : ka_sel;
      if (cmd_i.tick_begin) begin
        k_q          <= '0;
        issue_done_q <= 1'b0;
        p_vld_q      <= 1'b0;
        sel_cnt_q    <= '0;
        q_wr_q       <= '0;
        q_rd_q       <= '0;
      end
      if (cmd_i.tick_step) begin
        // Issue block k while the one before it is compared.
        p_vld_q <= !issue_done_q;
        if (!issue_done_q) begin
          k_q <= k_q + 1'b1;
          if (&k_q) issue_done_q <= 1'b1;
        end
      end
      if (proc && sel) begin
        prev_vld_q[p_k_q] <= 1'b1;
        sel_cnt_q         <= sel_cnt_q + 1'b1;
        q_wr_q            <= q_wr_q + 1'b1;
      end
      if (cmd_i.emit_header) begin
        fp_q       <= fp_q + 1'b1;
        draining_q <= 1'b1;
      end
      if (cmd_i.fetch_end) draining_q <= 1'b0;
      if (cmd_i.fetch_rd) q_rd_q <= q_rd_q + 1'b1;
    end
  end

  // Output register: hold until the transfer completes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.emit_header || cmd_i.fetch_end || cmd_i.emit_block) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_header) begin
      kind_o        <= KindHeader;
      length_o      <= {sel_cnt_q, 3'b000} + {{(LenW-CntW){1'b0}}, sel_cnt_q};
      block_index_o <= '0;
      block_data_o  <= '0;
    end else if (cmd_i.fetch_end) begin
      kind_o        <= KindEnd;
      length_o      <= '0;
      block_index_o <= '0;
      block_data_o  <= '0;
    end else if (cmd_i.emit_block) begin
      kind_o        <= KindBlock;
      length_o      <= '0;
      block_index_o <= q_rdata[QueueW-1:BlkW];
      block_data_o  <= q_rdata[BlkW-1:0];
    end
  end

endmodule
`default_nettype wire

// File: sim/bitplane_block_delta_encoder_tb.sv
// Self-checking testbench for the bit-plane block delta encoder with a built-in frame predictor.
`timescale 1ns / 100ps
`default_nettype none
module bitplane_block_delta_encoder_tb
  import bbde_pkg::*;
;

  localparam int WatchLimit = 5000;

  typedef struct {
    logic [1:0] func;
    logic [2:0] line;
    logic [6:0] column;
    logic [7:0] pixels;
    logic       force_req;
    logic       connected;
    bit         hold;
  } item_t;

  typedef struct {
    logic [1:0]         kind;
    logic [LenW-1:0]    length;
    logic [BlkIdxW-1:0] block_index;
    logic [BlkW-1:0]    block_data;
  } record_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic out_ready = 1'b0;
  logic in_ready, out_valid;
  item_t cur = '{FuncWrite, 3'd0, 7'd0, 8'd0, 1'b0, 1'b0, 1'b0};
  logic [1:0]         kind_o;
  logic [LenW-1:0]    length_o;
  logic [BlkIdxW-1:0] block_index_o;
  logic [BlkW-1:0]    block_data_o;

  item_t   pending_items[$];
  record_t expected_records[$];
  int      mismatches = 0;
  bit      stim_done = 1'b0;

  // frame state mirror
  logic [7:0]      disp_mem[1024];
  logic [BlkW-1:0] prev_frame[NumBlocks];
  bit              sel_mask[NumBlocks];
  logic [6:0]      force_ptr;
  logic [3:0]      alive_cnt;
  bit              frame_open;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  bitplane_block_delta_encoder u_top (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .func_i(cur.func), .line_i(cur.line), .column_i(cur.column), .pixels_i(cur.pixels),
    .force_req_i(cur.force_req), .connected_i(cur.connected),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .kind_o, .length_o, .block_index_o, .block_data_o
  );

  function automatic logic [BlkW-1:0] gather_plane(int k);
    logic [BlkW-1:0] v;
    int ln, b, base;
    ln = (k >> 4) & 7;
    b = (k >> 1) & 7;
    base = (k & 1) * 64;
    v = '0;
    for (int c = 0; c < 64; c++) v[c] = disp_mem[ln * 128 + base + c][b];
    return v;
  endfunction

  task automatic predict_frame(item_t it);
    logic [BlkW-1:0] blk;
    int cnt;
    bit sel;
    record_t r;
    cnt = 0;
    case (it.func)
      FuncWrite: disp_mem[it.line * 128 + it.column] = it.pixels;
      FuncTick: begin
        if (!frame_open) begin
          if (it.connected) alive_cnt = KeepReload;
          if (alive_cnt != 0) begin
            alive_cnt = alive_cnt - 4'd1;
            if (alive_cnt != 0) begin
              for (int k = 0; k < NumBlocks; k++) begin
                blk = gather_plane(k);
                sel = (blk != prev_frame[k]) || (k == force_ptr) || it.force_req;
                sel_mask[k] = sel;
                if (sel) begin
                  prev_frame[k] = blk;
                  cnt++;
                end
              end
              force_ptr = force_ptr + 7'd1;
              if (cnt != 0) begin
                frame_open = 1'b1;
                r = '{KindHeader, LenW'(cnt * 9), '0, '0};
                expected_records.push_back(r);
              end
            end
          end
        end
      end
      FuncFetch: begin
        if (frame_open) begin
          for (int k = 0; k < NumBlocks; k++) begin
            if (sel_mask[k] && cnt == 0) begin
              sel_mask[k] = 1'b0;
              r = '{KindBlock, '0, BlkIdxW'(k), prev_frame[k]};
              cnt = 1;
            end
          end
          if (cnt == 0) begin
            frame_open = 1'b0;
            r = '{KindEnd, '0, '0, '0};
          end
          expected_records.push_back(r);
        end
      end
      default: ;
    endcase
  endtask

  function automatic item_t mk(logic [1:0] f, logic [2:0] l, logic [6:0] c, logic [7:0] p,
                               logic fr, logic cn, bit h);
    item_t it;
    it = '{f, l, c, p, fr, cn, h};
    return it;
  endfunction

  task automatic add_fetches(int n);
    for (int i = 0; i < n; i++)
      pending_items.push_back(mk(FuncFetch, 3'($urandom), 7'($urandom), 8'($urandom),
                                 1'($urandom), 1'($urandom), 1'b0));
  endtask

  // stimulus
  initial begin
    int nw, nf;
    bit frc;
    for (int i = 0; i < 1024; i++) disp_mem[i] = '0;
    for (int i = 0; i < NumBlocks; i++) begin
      prev_frame[i] = '0;
      sel_mask[i] = 1'b0;
    end
    force_ptr = '0;
    alive_cnt = KeepReload;
    frame_open = 1'b0;

    // directed: stray fetch, unused code, field extremes, forced frame
    pending_items.push_back(mk(FuncFetch, 3'd0, 7'd0, 8'd0, 1'b0, 1'b0, 1'b0));
    pending_items.push_back(mk(2'd3, 3'd7, 7'd127, 8'hFF, 1'b1, 1'b1, 1'b0));
    pending_items.push_back(mk(FuncWrite, 3'd0, 7'd0, 8'hFF, 1'b0, 1'b0, 1'b0));
    pending_items.push_back(mk(FuncWrite, 3'd7, 7'd127, 8'hFF, 1'b0, 1'b0, 1'b0));
    pending_items.push_back(mk(FuncWrite, 3'd3, 7'd64, 8'hA5, 1'b0, 1'b0, 1'b0));
    pending_items.push_back(mk(FuncTick, 3'd0, 7'd0, 8'd0, 1'b1, 1'b1, 1'b0));
    add_fetches(3);
    // tick while a frame drains is dropped
    pending_items.push_back(mk(FuncTick, 3'd0, 7'd0, 8'd0, 1'b1, 1'b1, 1'b0));
    add_fetches(130);
    pending_items.push_back(mk(FuncWrite, 3'd7, 7'd127, 8'h00, 1'b0, 1'b0, 1'b0));
    // run keep-alive down to zero and past it, then revive
    for (int i = 0; i < 11; i++) begin
      pending_items.push_back(mk(FuncTick, 3'd0, 7'd0, 8'd0, 1'b0, 1'b0, i == 3));
      add_fetches(4);
    end
    pending_items.push_back(mk(FuncTick, 3'd0, 7'd0, 8'd0, 1'b0, 1'b1, 1'b0));
    add_fetches(4);

    // random frames: writes, tick, fetches; some short drains
    while (pending_items.size() < 1700) begin
      nw = $urandom_range(0, 6);
      for (int i = 0; i < nw; i++)
        pending_items.push_back(mk(FuncWrite, 3'($urandom), 7'($urandom), 8'($urandom),
                                   1'($urandom), 1'($urandom), 1'b0));
      if ($urandom_range(0, 19) == 0)
        pending_items.push_back(mk(2'd3, 3'($urandom), 7'($urandom), 8'($urandom),
                                   1'($urandom), 1'($urandom), 1'b0));
      frc = ($urandom_range(0, 15) == 0);
      pending_items.push_back(mk(FuncTick, 3'($urandom), 7'($urandom), 8'($urandom),
                                 frc, $urandom_range(0, 9) < 8, $urandom_range(0, 9) == 0));
      nf = frc ? 130 : (8 * nw + 2);
      if ($urandom_range(0, 4) == 0) nf = $urandom_range(0, nf);
      add_fetches(nf);
    end
    stim_done = 1'b1;
  end

  // driver: bursts with random gaps
  int burst_left = 4;
  int gap_left = 0;
  always @(posedge clk_i) begin
    logic nv;
    item_t nxt;
    if (rst_ni) begin
      nv = in_valid;
      if (in_valid && in_ready) begin
        predict_frame(cur);
        nv = 1'b0;
      end
      if (!nv) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_items.size() > 0 &&
                     !(pending_items[0].hold && expected_records.size() > 0)) begin
          nxt = pending_items.pop_front();
          cur <= nxt;
          nv = 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
          end
        end
      end
      in_valid <= nv;
    end
  end

  // receiver stall pattern: phases of always-ready, random, and long stalls
  int rx_phase = 0;
  int rx_left = 0;
  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_phase = $urandom_range(0, 2);
      rx_left = $urandom_range(5, 60);
    end
    rx_left--;
    case (rx_phase)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom);
      default: out_ready <= (rx_left % 16) == 0;
    endcase
  end

  // monitor
  always @(posedge clk_i) begin
    record_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (expected_records.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected record kind=%0d len=%0d idx=%0d data=%h",
                   kind_o, length_o, block_index_o, block_data_o);
      end else begin
        want = expected_records.pop_front();
        if (kind_o !== want.kind || length_o !== want.length ||
            block_index_o !== want.block_index || block_data_o !== want.block_data) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp kind=%0d len=%0d idx=%0d data=%h got kind=%0d len=%0d idx=%0d data=%h",
                     want.kind, want.length, want.block_index, want.block_data,
                     kind_o, length_o, block_index_o, block_data_o);
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WatchLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (stim_done);
    while (pending_items.size() > 0 || in_valid || expected_records.size() > 0)
      @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (mismatches == 0 && expected_records.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
